[hdl/isc_pkg.sv]
`default_nettype none

package isc_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int WORD_W       = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef struct packed {
        word_t value;
        logic  end_of_set;
    } in_item_t;

    typedef struct packed {
        word_t sorted_value;
        logic  final_res;
        logic  overflowed;
    } out_item_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

endpackage

`default_nettype wire

[hdl/isc_cell.sv]
`default_nettype none

module isc_cell (
    input  wire                logic       clk,
    input  wire isc_pkg::cell_ctrl_t       ctrl,
    input  wire isc_pkg::word_t            value,
    input  wire                logic       occupied,
    input  wire isc_pkg::word_t            left_data,
    input  wire                logic       left_gt,
    input  wire isc_pkg::word_t            right_data,
    output      isc_pkg::word_t            data,
    output      logic                      gt
);

    isc_pkg::word_t data_reg;
    isc_pkg::word_t data_next;

    assign data = data_reg;

    // sorted list: gt is a run of ones from the insertion point up to the fill count
    assign gt = occupied && (value < data_reg);

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.shift)
        begin
            data_next = right_data;
        end
        else if (ctrl.load && (gt || !occupied))
        begin
            data_next = left_gt ? left_data : value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

endmodule

`default_nettype wire

[hdl/insertion_sorter.sv]
// channel  | handshake               | payload
// ---------+-------------------------+----------------------------------------
// input    | start, busy             | din    (value, end_of_set)
// result   | result_valid (strobe)   | result (sorted_value, final_res, overflowed)
//
// With busy low, one item per cycle is taken and inserted (dropped once full).
// After an end_of_set item the chain shifts out one result per cycle, one for
// each stored entry (1 to CAPACITY), with busy high.
// Reset empties the list and clears the overflow flag; no clearing pass.
// The receiver cannot stall: each result shows for exactly one cycle.
`default_nettype none

module insertion_sorter #(
    parameter int CAPACITY = isc_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output      logic               busy,
    input  wire isc_pkg::in_item_t  din,
    output      logic               result_valid,
    output      isc_pkg::out_item_t result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    isc_pkg::state_t     state_reg;
    isc_pkg::state_t     state_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                ovf_reg;
    logic                ovf_next;

    logic                accept;
    logic                full;
    logic                last_out;
    isc_pkg::cell_ctrl_t ctrl;

    isc_pkg::word_t      cell_data [CAPACITY];
    logic                cell_gt   [CAPACITY];

    assign accept   = start && !busy;
    assign full     = (count_reg == CNT_W'(CAPACITY));
    assign last_out = (count_reg == CNT_W'(1));

    assign ctrl.load  = accept && !full;
    assign ctrl.shift = (state_reg == isc_pkg::ST_DRAIN);

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            isc_pkg::word_t left_d;
            isc_pkg::word_t right_d;
            logic           left_g;

            if (i == 0)
            begin : g_first
                assign left_d = din.value;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_d = cell_data[i-1];
                assign left_g = cell_gt[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_last
                assign right_d = cell_data[i];
            end
            else
            begin : g_inner
                assign right_d = cell_data[i+1];
            end

            isc_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .value      (din.value),
                .occupied   (CNT_W'(i) < count_reg),
                .left_data  (left_d),
                .left_gt    (left_g),
                .right_data (right_d),
                .data       (cell_data[i]),
                .gt         (cell_gt[i])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            isc_pkg::ST_LOAD:
            begin
                if (accept && din.end_of_set)
                begin
                    state_next = isc_pkg::ST_DRAIN;
                end
            end
            isc_pkg::ST_DRAIN:
            begin
                if (last_out)
                begin
                    state_next = isc_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = isc_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (ctrl.shift)
        begin
            count_next = count_reg - CNT_W'(1);
            if (last_out)
            begin
                ovf_next = 1'b0;
            end
        end
        else if (accept)
        begin
            if (full)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        busy                = 1'b0;
        result_valid        = 1'b0;
        result.sorted_value = cell_data[0];
        result.final_res    = last_out;
        result.overflowed   = ovf_reg;
        unique case (state_reg)
            isc_pkg::ST_LOAD:
            begin
                busy         = 1'b0;
                result_valid = 1'b0;
            end
            isc_pkg::ST_DRAIN:
            begin
                busy         = 1'b1;
                result_valid = 1'b1;
            end
            default:
            begin
                busy         = 1'b0;
                result_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= isc_pkg::ST_LOAD;
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end

`ifndef ASSERT_OFF
    a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> count_reg != '0)
        else $error("result strobe with empty list");

    a_eos_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && din.end_of_set) |=> result_valid)
        else $error("end of set did not start output");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.final_res) |=> result_valid)
        else $error("output run broke before final item");

    a_drain_counts_down: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.final_res) |=>
            count_reg == $past(count_reg) - CNT_W'(1))
        else $error("count did not step down during output");

    a_final_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.final_res) |=> (!busy && !ovf_reg && count_reg == '0))
        else $error("state not cleared after final item");
`endif

endmodule

`default_nettype wire

[sim/sorted_run_checker.sv]
`timescale 1ns / 100ps

module sorted_run_checker #(
    parameter int CAPACITY = isc_pkg::CAPACITY_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire isc_pkg::in_item_t  din,
    input  wire logic               result_valid,
    input  wire isc_pkg::out_item_t result,
    output int                      fail_count,
    output int                      pending,
    output int                      items_seen,
    output int                      results_seen,
    output int                      sets_seen,
    output int                      overflow_sets
);

    localparam int REPORT_MAX = 10;

    // sorted list as the block should hold it
    isc_pkg::word_t     held [CAPACITY];
    int                 held_count;
    logic               held_dropped;
    isc_pkg::out_item_t sorted_due [$];
    isc_pkg::out_item_t want;

    int n_fail;
    int n_items;
    int n_results;
    int n_sets;
    int n_over;

    assign fail_count    = n_fail;
    assign pending       = sorted_due.size();
    assign items_seen    = n_items;
    assign results_seen  = n_results;
    assign sets_seen     = n_sets;
    assign overflow_sets = n_over;

    // stable insert: goes before the first entry strictly greater
    function automatic void place_word(isc_pkg::word_t v);
        int pos;
        if (held_count >= CAPACITY)
        begin
            held_dropped = 1'b1;
            return;
        end
        pos = held_count;
        for (int k = 0; k < held_count; k++)
        begin
            if (v < held[k])
            begin
                pos = k;
                break;
            end
        end
        for (int k = held_count; k > pos; k--)
            held[k] = held[k-1];
        held[pos] = v;
        held_count++;
    endfunction

    function automatic void note_fail();
        n_fail++;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count   = 0;
            held_dropped = 1'b0;
            sorted_due.delete();
            n_fail       = 0;
            n_items      = 0;
            n_results    = 0;
            n_sets       = 0;
            n_over       = 0;
        end
        else
        begin
            if (result_valid)
            begin
                n_results++;
                if (sorted_due.size() == 0)
                begin
                    if (n_fail < REPORT_MAX)
                        $display("%0t: result %0d with nothing due", $time,
                                 result.sorted_value);
                    note_fail();
                end
                else
                begin
                    want = sorted_due.pop_front();
                    if (result.sorted_value !== want.sorted_value ||
                        result.final_res !== want.final_res ||
                        result.overflowed !== want.overflowed)
                    begin
                        if (n_fail < REPORT_MAX)
                            $display({"%0t: value exp %0d got %0d, final exp %0b got %0b,",
                                      " overflow exp %0b got %0b"},
                                     $time, want.sorted_value, result.sorted_value,
                                     want.final_res, result.final_res,
                                     want.overflowed, result.overflowed);
                        note_fail();
                    end
                end
            end

            if (start && !busy)
            begin
                n_items++;
                place_word(din.value);
                if (din.end_of_set)
                begin
                    for (int k = 0; k < held_count; k++)
                        sorted_due.push_back('{sorted_value: held[k],
                                               final_res: (k == held_count - 1),
                                               overflowed: held_dropped});
                    n_sets++;
                    if (held_dropped)
                        n_over++;
                    held_count   = 0;
                    held_dropped = 1'b0;
                end
            end
        end
    end

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    localparam int             CAP        = isc_pkg::CAPACITY_DEF;
    localparam int             ITEM_GOAL  = 500;
    localparam int             QUIET_MAX  = 2000;
    localparam isc_pkg::word_t WORD_MIN   = {1'b1, {(isc_pkg::WORD_W-1){1'b0}}};
    localparam isc_pkg::word_t WORD_MAX   = {1'b0, {(isc_pkg::WORD_W-1){1'b1}}};

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    isc_pkg::in_item_t  din;
    logic               result_valid;
    isc_pkg::out_item_t result;

    int fail_count;
    int pending;
    int items_seen;
    int results_seen;
    int sets_seen;
    int overflow_sets;

    int sent;
    int quiet;
    bit gaps_on;

    insertion_sorter #(
        .CAPACITY (CAP)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .din          (din),
        .result_valid (result_valid),
        .result       (result)
    );

    sorted_run_checker #(
        .CAPACITY (CAP)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .din           (din),
        .result_valid  (result_valid),
        .result        (result),
        .fail_count    (fail_count),
        .pending       (pending),
        .items_seen    (items_seen),
        .results_seen  (results_seen),
        .sets_seen     (sets_seen),
        .overflow_sets (overflow_sets)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            quiet <= 0;
        else if (quiet >= QUIET_MAX)
        begin
            $display("timeout: no activity for %0d cycles", QUIET_MAX);
            $display("FAILED: results differ");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    function automatic isc_pkg::word_t pick_value();
        case ($urandom_range(0, 7)) inside
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return WORD_MIN;
                    1: return WORD_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            1, 2: return isc_pkg::word_t'(int'($urandom_range(0, 15)) - 8);
            default: return isc_pkg::word_t'($urandom);
        endcase
    endfunction

    task automatic send_item(input isc_pkg::word_t v, input logic eos);
        if (gaps_on && $urandom_range(0, 99) < 9)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        start <= 1'b1;
        din   <= '{value: v, end_of_set: eos};
        do
            @(posedge clk);
        while (busy);
        sent++;
        gaps_on = !(sent >= 200 && sent < 320);
    endtask

    task automatic send_set(input isc_pkg::word_t vals [$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    task automatic send_random_set(input int len);
        for (int i = 0; i < len; i++)
            send_item(pick_value(), i == len - 1);
    endtask

    // hold off until the block has drained everything
    task automatic drain_wait();
        start <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        @(posedge clk);
    endtask

    initial
    begin
        int len;
        rst_n   = 1'b0;
        start   = 1'b0;
        din     = '0;
        sent    = 0;
        quiet   = 0;
        gaps_on = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_set('{WORD_MAX});
        send_set('{WORD_MIN});
        send_set('{isc_pkg::word_t'(0), isc_pkg::word_t'(-1), WORD_MAX, WORD_MIN,
                   isc_pkg::word_t'(1), isc_pkg::word_t'(-1), isc_pkg::word_t'(0)});
        send_set('{isc_pkg::word_t'(30), isc_pkg::word_t'(20), isc_pkg::word_t'(10),
                   isc_pkg::word_t'(0), isc_pkg::word_t'(-10)});
        send_set('{isc_pkg::word_t'(-3), isc_pkg::word_t'(-2), isc_pkg::word_t'(-1)});
        send_set('{isc_pkg::word_t'(7), isc_pkg::word_t'(7), isc_pkg::word_t'(7)});
        send_set('{isc_pkg::word_t'(32'h5555_5555), isc_pkg::word_t'(32'haaaa_aaaa)});
        drain_wait();

        // full store, one dropped on the marking item, several dropped
        send_random_set(CAP);
        send_random_set(CAP + 1);
        send_random_set(CAP + 6);

        while (sent < ITEM_GOAL)
        begin
            case ($urandom_range(0, 9))
                0: len = $urandom_range(CAP - 4, CAP + 6);
                1: len = $urandom_range(11, 40);
                default: len = $urandom_range(1, 10);
            endcase
            send_random_set(len);
            if ($urandom_range(0, 7) == 0)
                drain_wait();
        end

        drain_wait();
        repeat (CAP + 8) @(posedge clk);

        $display("run: %0d items in %0d sets, %0d sorted results", items_seen, sets_seen,
                 results_seen);
        $display("run: %0d sets ran past the store limit", overflow_sets);
        if (fail_count == 0 && pending == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
